/* design/ctp_pkg.sv */
// Shared constants for the compacting text pool: command and status codes,
// fixed field widths and default sizes. No dependencies.
`default_nettype none
package ctp_pkg;

  localparam int DEF_PROFILES   = 4;
  localparam int DEF_KEYS       = 9;
  localparam int DEF_POOL_BYTES = 1024;
  localparam int DEF_TEXT_MAX   = 64;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int BYTE_W   = 8;
  localparam int TLEN_W   = 7;
  localparam int USED_OUT_W = 11;
  // Room check sum: pool use up to 1024 plus a requested length up to 255.
  localparam int CHK_W    = 12;

  localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SET   = 3'd4;

endpackage
`default_nettype wire

/* design/ctp_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module ctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

/* design/compacting_text_pool.sv */
// Top level of the compacting text pool: command sequencer, slot reference
// table and byte pool. Depends on ctp_pkg and ctp_ram.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_stall_o | command, profile, key, length, data_byte
//   out     | output    | out_valid_o / out_stall_i | status, text_byte, text_length,
//           |           |                        | bytes_used, last
//
// One command is handled at a time; in_stall_o is high until it is finished.
// A data byte passes through the REF and EMIT states; a read alternates between RD_ADDR and RD_DATA for each text byte.
// A set that removes a text moves the bytes above it through the pool RAM's
// single read and write ports, one byte a cycle, then rescans every slot
// reference, one a cycle.
// After reset all slot references read as empty; no clearing pass is needed.
// A stalled output holds its transfer; the sequencer waits on it.
`default_nettype none
module compacting_text_pool
  import ctp_pkg::*;
#(
  parameter int PROFILES   = DEF_PROFILES,
  parameter int KEYS       = DEF_KEYS,
  parameter int POOL_BYTES = DEF_POOL_BYTES,
  parameter int TEXT_MAX   = DEF_TEXT_MAX
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [CMD_W-1:0]      command_i,
  input  wire logic [2:0]            profile_i,
  input  wire logic [3:0]            key_i,
  input  wire logic [BYTE_W-1:0]     length_i,
  input  wire logic [BYTE_W-1:0]     data_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [BYTE_W-1:0]          text_byte_o,
  output logic [TLEN_W-1:0]          text_length_o,
  output logic [USED_OUT_W-1:0]      bytes_used_o,
  output logic                       last_o
);

  localparam int SLOT_COUNT = PROFILES * KEYS;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OFF_W  = $clog2(POOL_BYTES);
  localparam int USED_W = $clog2(POOL_BYTES + 1);
  localparam int LEN_W  = $clog2(TEXT_MAX + 1);
  localparam int REF_W  = OFF_W + LEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_REF, S_MOVE, S_SCAN, S_SETUP, S_EMIT, S_RD_ADDR, S_RD_DATA
  } state_e;

  state_e state_q, state_d;

  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                bad_q, bad_d;
  logic [BYTE_W-1:0]   len_q, len_d;
  logic [BYTE_W-1:0]   dbyte_q, dbyte_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [SLOT_W-1:0]   open_q, open_d;
  logic [LEN_W-1:0]    pend_q, pend_d;
  logic [OFF_W-1:0]    roff_q, roff_d;
  logic [LEN_W-1:0]    rlen_q, rlen_d;
  logic [USED_W-1:0]   src_q, src_d;
  logic [OFF_W-1:0]    dst_q, dst_d;
  logic                mv_v_q, mv_v_d;
  logic [SLOT_W:0]     sidx_q, sidx_d;
  logic [SLOT_W-1:0]   swr_q, swr_d;
  logic                sv_q, sv_d;
  logic [LEN_W-1:0]    rcnt_q, rcnt_d;
  logic [STATUS_W-1:0] res_q, res_d;

  logic                out_valid_d;
  logic [STATUS_W-1:0] status_d;
  logic [BYTE_W-1:0]   text_byte_d;
  logic [TLEN_W-1:0]   text_length_d;
  logic [USED_OUT_W-1:0] bytes_used_d;
  logic                last_d;

  // Pool RAM ports.
  logic              pool_wr_en, pool_rd_en;
  logic [OFF_W-1:0]  pool_wr_addr, pool_rd_addr;
  logic [BYTE_W-1:0] pool_wr_data, pool_rd_data;

  // Slot reference RAM ports, with a valid bit per entry so reset reads empty.
  logic              ref_wr_en, ref_rd_en;
  logic [SLOT_W-1:0] ref_wr_addr, ref_rd_addr;
  logic [REF_W-1:0]  ref_wr_data, ref_rd_raw;
  logic [SLOT_COUNT-1:0] ref_valid_q;
  logic              ref_rv_q;
  logic [OFF_W-1:0]  ref_off;
  logic [LEN_W-1:0]  ref_len;

  logic              in_xfer, out_free;
  logic [7:0]        slot_full;
  logic [SLOT_W-1:0] slot_c;
  logic              bad_c;
  logic              consistent;
  logic [CHK_W-1:0]  others;

  ctp_ram #(.WIDTH(BYTE_W), .DEPTH(POOL_BYTES)) u_pool (
    .clk_i     (clk_i),
    .wr_en_i   (pool_wr_en),
    .wr_addr_i (pool_wr_addr),
    .wr_data_i (pool_wr_data),
    .rd_en_i   (pool_rd_en),
    .rd_addr_i (pool_rd_addr),
    .rd_data_o (pool_rd_data)
  );

  ctp_ram #(.WIDTH(REF_W), .DEPTH(SLOT_COUNT)) u_refs (
    .clk_i     (clk_i),
    .wr_en_i   (ref_wr_en),
    .wr_addr_i (ref_wr_addr),
    .wr_data_i (ref_wr_data),
    .rd_en_i   (ref_rd_en),
    .rd_addr_i (ref_rd_addr),
    .rd_data_o (ref_rd_raw)
  );

  assign ref_off = ref_rv_q ? ref_rd_raw[REF_W-1:LEN_W] : '0;
  assign ref_len = ref_rv_q ? ref_rd_raw[LEN_W-1:0] : '0;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  assign slot_full = 8'(profile_i) * 8'(KEYS) + 8'(key_i);
  assign slot_c    = slot_full[SLOT_W-1:0];
  assign bad_c     = (4'(profile_i) >= 4'(PROFILES)) || (5'(key_i) >= 5'(KEYS));

  assign consistent = ((USED_W+1)'(ref_off) + (USED_W+1)'(ref_len)) <=
                      (USED_W+1)'(used_q);
  assign others = consistent ? CHK_W'(used_q) - CHK_W'(ref_len) : CHK_W'(used_q);

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;  slot_d = slot_q;  bad_d = bad_q;  len_d = len_q;  dbyte_d = dbyte_q;
    used_d = used_q;  open_d = open_q;  pend_d = pend_q;
    roff_d = roff_q;  rlen_d = rlen_q;  src_d = src_q;  dst_d = dst_q;  mv_v_d = 1'b0;
    sidx_d = sidx_q;  swr_d = swr_q;  sv_d = 1'b0;  rcnt_d = rcnt_q;  res_d = res_q;

    out_valid_d   = out_valid_o && out_stall_i;
    status_d      = status_o;
    text_byte_d   = text_byte_o;
    text_length_d = text_length_o;
    bytes_used_d  = bytes_used_o;
    last_d        = last_o;

    pool_wr_en = 1'b0;  pool_wr_addr = used_q[OFF_W-1:0];  pool_wr_data = dbyte_q;
    pool_rd_en = 1'b0;  pool_rd_addr = src_q[OFF_W-1:0];
    ref_wr_en  = 1'b0;  ref_wr_addr  = slot_q;  ref_wr_data = '0;
    ref_rd_en  = 1'b0;  ref_rd_addr  = slot_c;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d   = command_i;
          slot_d  = slot_c;
          bad_d   = bad_c;
          len_d   = length_i;
          dbyte_d = data_byte_i;
          ref_rd_en   = 1'b1;
          ref_rd_addr = (command_i == CMD_DATA) ? open_q : slot_c;
          if (command_i == CMD_SET || command_i == CMD_DATA || command_i == CMD_READ) begin
            state_d = S_REF;
          end
        end
      end

      S_REF: begin
        state_d = S_EMIT;
        res_d   = ST_OK;
        unique case (cmd_q)
          CMD_SET: begin
            pend_d = '0;
            if (bad_q) begin
              res_d = ST_BAD_IDX;
            end else if (len_q > 8'(TEXT_MAX)) begin
              res_d = ST_TOO_LONG;
            end else if (others + CHK_W'(len_q) > CHK_W'(POOL_BYTES)) begin
              res_d = ST_FULL;
            end else begin
              state_d = S_SETUP;
              if (ref_len != '0) begin
                ref_wr_en   = 1'b1;
                ref_wr_addr = slot_q;
                ref_wr_data = '0;
                roff_d = ref_off;
                rlen_d = ref_len;
                if (consistent) begin
                  src_d   = USED_W'(ref_off) + USED_W'(ref_len);
                  dst_d   = ref_off;
                  state_d = S_MOVE;
                end
              end
            end
          end
          CMD_DATA: begin
            if (pend_q == '0) begin
              res_d = ST_NO_SET;
            end else if (used_q >= USED_W'(POOL_BYTES)) begin
              pend_d = '0;
              res_d  = ST_FULL;
            end else begin
              pool_wr_en   = 1'b1;
              pool_wr_addr = used_q[OFF_W-1:0];
              pool_wr_data = dbyte_q;
              ref_wr_en    = 1'b1;
              ref_wr_addr  = open_q;
              ref_wr_data  = {ref_off, ref_len + LEN_W'(1)};
              used_d = used_q + USED_W'(1);
              pend_d = pend_q - LEN_W'(1);
            end
          end
          default: begin
            if (bad_q) begin
              res_d = ST_BAD_IDX;
            end else if (ref_len != '0 && ref_len <= LEN_W'(TEXT_MAX) && consistent) begin
              roff_d  = ref_off;
              rlen_d  = ref_len;
              rcnt_d  = '0;
              state_d = S_RD_ADDR;
            end
          end
        endcase
      end

      // Bytes above the removed text slide down; each byte is written in the cycle after its read.
      S_MOVE: begin
        if (src_q < used_q) begin
          pool_rd_en   = 1'b1;
          pool_rd_addr = src_q[OFF_W-1:0];
          src_d  = src_q + USED_W'(1);
          mv_v_d = 1'b1;
        end
        if (mv_v_q) begin
          pool_wr_en   = 1'b1;
          pool_wr_addr = dst_q;
          pool_wr_data = pool_rd_data;
          dst_d = dst_q + OFF_W'(1);
        end
        if (!(src_q < used_q) && !mv_v_q) begin
          used_d  = used_q - USED_W'(rlen_q);
          sidx_d  = '0;
          state_d = S_SCAN;
        end
      end

      // Every reference above the removed text is lowered by the removed text's length.
      S_SCAN: begin
        if (sidx_q < (SLOT_W+1)'(SLOT_COUNT)) begin
          ref_rd_en   = 1'b1;
          ref_rd_addr = sidx_q[SLOT_W-1:0];
          swr_d  = sidx_q[SLOT_W-1:0];
          sidx_d = sidx_q + (SLOT_W+1)'(1);
          sv_d   = 1'b1;
        end
        if (sv_q && ref_len != '0 && ref_off > roff_q) begin
          ref_wr_en   = 1'b1;
          ref_wr_addr = swr_q;
          ref_wr_data = {ref_off - OFF_W'(rlen_q), ref_len};
        end
        if (!(sidx_q < (SLOT_W+1)'(SLOT_COUNT)) && !sv_q) begin
          state_d = S_SETUP;
        end
      end

      S_SETUP: begin
        if (len_q != '0) begin
          ref_wr_en   = 1'b1;
          ref_wr_addr = slot_q;
          ref_wr_data = {used_q[OFF_W-1:0], LEN_W'(0)};
          open_d = slot_q;
          pend_d = len_q[LEN_W-1:0];
        end
        res_d   = ST_OK;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          status_d      = res_q;
          text_byte_d   = '0;
          text_length_d = '0;
          bytes_used_d  = USED_OUT_W'(used_q);
          last_d        = 1'b1;
          state_d       = S_IDLE;
        end
      end

      S_RD_ADDR: begin
        pool_rd_en   = 1'b1;
        pool_rd_addr = roff_q + OFF_W'(rcnt_q);
        state_d      = S_RD_DATA;
      end

      default: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          status_d      = ST_OK;
          text_byte_d   = pool_rd_data;
          text_length_d = TLEN_W'(rlen_q);
          bytes_used_d  = USED_OUT_W'(used_q);
          last_d        = (rcnt_q + LEN_W'(1)) == rlen_q;
          rcnt_d        = rcnt_q + LEN_W'(1);
          state_d       = ((rcnt_q + LEN_W'(1)) == rlen_q) ? S_IDLE : S_RD_ADDR;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q <= '0;  slot_q <= '0;  bad_q <= 1'b0;  len_q <= '0;  dbyte_q <= '0;
      used_q <= '0;  open_q <= '0;  pend_q <= '0;
      roff_q <= '0;  rlen_q <= '0;  src_q <= '0;  dst_q <= '0;  mv_v_q <= 1'b0;
      sidx_q <= '0;  swr_q <= '0;  sv_q <= 1'b0;  rcnt_q <= '0;  res_q <= ST_OK;
      out_valid_o   <= 1'b0;
      status_o      <= '0;
      text_byte_o   <= '0;
      text_length_o <= '0;
      bytes_used_o  <= '0;
      last_o        <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q <= cmd_d;  slot_q <= slot_d;  bad_q <= bad_d;  len_q <= len_d;  dbyte_q <= dbyte_d;
      used_q <= used_d;  open_q <= open_d;  pend_q <= pend_d;
      roff_q <= roff_d;  rlen_q <= rlen_d;  src_q <= src_d;  dst_q <= dst_d;  mv_v_q <= mv_v_d;
      sidx_q <= sidx_d;  swr_q <= swr_d;  sv_q <= sv_d;  rcnt_q <= rcnt_d;  res_q <= res_d;
      out_valid_o   <= out_valid_d;
      status_o      <= status_d;
      text_byte_o   <= text_byte_d;
      text_length_o <= text_length_d;
      bytes_used_o  <= bytes_used_d;
      last_o        <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_valid_q <= '0;
      ref_rv_q    <= 1'b0;
    end else begin
      if (ref_wr_en) begin
        ref_valid_q[ref_wr_addr] <= 1'b1;
      end
      if (ref_rd_en) begin
        ref_rv_q <= ref_valid_q[ref_rd_addr];
      end
    end
  end

endmodule
`default_nettype wire
